/* rtl/hph_pkg.sv */
package hph_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 2;

	// Q constants: 0.1 (slow speed) and 0.001 (wind gain), rounded
	localparam logic [30:0] SLOW_SPEED = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [32:0] WIND_GAIN = 33'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

	// reset values of the gain registers
	localparam logic [30:0] POS_GAIN_RST = 31'd19661;
	localparam logic [30:0] VEL_GAIN_RST = 31'd65536;
	localparam logic [30:0] WIND_LIM_RST = 31'd655360;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_GAIN = 2'd0,
		REG_VEL_GAIN = 2'd1,
		REG_WIND_LIM = 2'd2
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_WMX, ST_WMY, ST_WAY, ST_CSX, ST_CSY, ST_CLIM, ST_CCMP,
		ST_SQRT, ST_DMX, ST_DIVX, ST_DMY, ST_DIVY, ST_DWY,
		ST_PX, ST_PY, ST_VX, ST_VY, ST_QX, ST_QY,
		ST_R1, ST_R2, ST_R3, ST_R4, ST_R5
	} state_t;

	// saturate a 33-bit sum to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v > 33'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -33'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33(33'(a) + 33'(b));
	endfunction

	function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat33(33'(a) - 33'(b));
	endfunction

	// round half up, drop fraction bits, saturate to 32 bits
	function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v);
		logic signed [66:0] t;
		logic signed [66:0] s;
		t = 67'(v) + (67'sd1 <<< (FRAC_BITS - 1));
		s = t >>> FRAC_BITS;
		if (s > 67'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (s < -67'sd2147483648) begin
			return 32'sh80000000;
		end
		return s[31:0];
	endfunction

endpackage

/* rtl/hph_ifs.sv */
interface hph_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic signed [31:0] target_x;
	logic signed [31:0] target_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic [30:0]        ground_speed;
	logic signed [17:0] yaw_cos;
	logic signed [17:0] yaw_sin;
	logic               clear_wind;
	modport source(output valid, est_x, est_y, target_x, target_y, vel_x, vel_y,
		ground_speed, yaw_cos, yaw_sin, clear_wind, input ready);
	modport sink(input valid, est_x, est_y, target_x, target_y, vel_x, vel_y,
		ground_speed, yaw_cos, yaw_sin, clear_wind, output ready);
endinterface

interface hph_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pitch_cmd;
	logic signed [31:0] roll_cmd;
	modport source(output valid, pitch_cmd, roll_cmd, input ready);
	modport sink(input valid, pitch_cmd, roll_cmd, output ready);
endinterface

interface hph_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [hph_pkg::CFG_IDX_W-1:0]  index;
	logic [30:0]                    data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

/* rtl/horizontal_position_hold.sv */
// Position-hold tilt controller with wind estimate. One 33x33 multiplier is
// shared by all products under a sequencer, and a bit-serial square root
// and divider clamp the wind vector. The wind estimate is integrated, and
// clamped when the wind vector exceeds the limit, only when the ground
// speed is below 0.1; input ready is high only in idle. A finished word
// waits in the output register while the next word is accepted, and the
// last step stalls while that register is still full; config writes are
// always ready and must come while the block is idle.
module horizontal_position_hold (
	input  logic        clk,
	input  logic        arst_n,
	hph_in_if.sink      item_in,
	hph_out_if.source   item_out,
	hph_cfg_if.sink     cfg
);

	hph_pkg::state_t state_q, state_d;

	logic [30:0] kp_q, kd_q, lim_q;
	logic signed [31:0] wind_x_q, wind_y_q, last_x_q, last_y_q;
	logic signed [31:0] ex_q, ey_q, tx_q, ty_q, vx_q, vy_q;
	logic signed [17:0] yc_q, ys_q;
	logic signed [31:0] px_q, py_q, sx_q, sy_q, pitch_q;
	logic signed [65:0] prod_q, acc_q;
	logic [63:0] sq_v_q, sq_r_q, sq_bit_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	logic signed [31:0] out_pitch_q, out_roll_q;

	logic signed [32:0] op_a, op_b;
	logic signed [65:0] mul_p;
	logic [63:0] sq_t;
	logic [32:0] div_t;
	logic signed [64:0] quo_s;
	logic signed [31:0] div_res;
	logic signed [31:0] rnd_p;
	logic accept;

	assign accept = item_in.valid && item_in.ready;
	assign item_in.ready = (state_q == hph_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign item_out.valid = out_valid_q;
	assign item_out.pitch_cmd = out_pitch_q;
	assign item_out.roll_cmd = out_roll_q;

	assign rnd_p = hph_pkg::rnd_sat(prod_q);
	assign sq_t = sq_r_q + sq_bit_q;
	assign div_t = {rem_q, quo_q[63]};
	assign quo_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign div_res = hph_pkg::sat33(quo_s[32:0]);

	// select multiplier operands for the current step
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			hph_pkg::ST_WMX: begin
				op_a = 33'(hph_pkg::sub_s(last_x_q, wind_x_q));
				op_b = hph_pkg::WIND_GAIN;
			end
			hph_pkg::ST_WMY: begin
				op_a = 33'(hph_pkg::sub_s(last_y_q, wind_y_q));
				op_b = hph_pkg::WIND_GAIN;
			end
			hph_pkg::ST_CSX: begin
				op_a = 33'(wind_x_q);
				op_b = 33'(wind_x_q);
			end
			hph_pkg::ST_CSY: begin
				op_a = 33'(wind_y_q);
				op_b = 33'(wind_y_q);
			end
			hph_pkg::ST_CLIM: begin
				op_a = {2'b00, lim_q};
				op_b = {2'b00, lim_q};
			end
			hph_pkg::ST_DMX: begin
				op_a = 33'(wind_x_q);
				op_b = {2'b00, lim_q};
			end
			hph_pkg::ST_DMY: begin
				op_a = 33'(wind_y_q);
				op_b = {2'b00, lim_q};
			end
			hph_pkg::ST_PX: begin
				op_a = 33'(hph_pkg::sub_s(ex_q, tx_q));
				op_b = {2'b00, kp_q};
			end
			hph_pkg::ST_PY: begin
				op_a = 33'(hph_pkg::sub_s(ey_q, ty_q));
				op_b = {2'b00, kp_q};
			end
			hph_pkg::ST_VX: begin
				op_a = 33'(vx_q);
				op_b = {2'b00, kd_q};
			end
			hph_pkg::ST_VY: begin
				op_a = 33'(vy_q);
				op_b = {2'b00, kd_q};
			end
			hph_pkg::ST_QX: begin
				op_a = 33'(sx_q);
				op_b = sx_q < 0 ? -33'(sx_q) : 33'(sx_q);
			end
			hph_pkg::ST_QY: begin
				op_a = 33'(sy_q);
				op_b = sy_q < 0 ? -33'(sy_q) : 33'(sy_q);
			end
			hph_pkg::ST_R1: begin
				op_a = 33'(yc_q);
				op_b = 33'(last_x_q);
			end
			hph_pkg::ST_R2: begin
				op_a = 33'(ys_q);
				op_b = 33'(last_y_q);
			end
			hph_pkg::ST_R3: begin
				op_a = 33'(yc_q);
				op_b = 33'(last_y_q);
			end
			// keep the last product steady while the output word waits
			hph_pkg::ST_R4, hph_pkg::ST_R5: begin
				op_a = 33'(ys_q);
				op_b = 33'(last_x_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_p = op_a * op_b;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hph_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (item_in.ground_speed < hph_pkg::SLOW_SPEED) ?
						hph_pkg::ST_WMX : hph_pkg::ST_PX;
				end
			end
			hph_pkg::ST_WMX:  state_d = hph_pkg::ST_WMY;
			hph_pkg::ST_WMY:  state_d = hph_pkg::ST_WAY;
			hph_pkg::ST_WAY:  state_d = hph_pkg::ST_CSX;
			hph_pkg::ST_CSX:  state_d = hph_pkg::ST_CSY;
			hph_pkg::ST_CSY:  state_d = hph_pkg::ST_CLIM;
			hph_pkg::ST_CLIM: state_d = hph_pkg::ST_CCMP;
			hph_pkg::ST_CCMP: state_d = (acc_q > prod_q) ? hph_pkg::ST_SQRT : hph_pkg::ST_PX;
			hph_pkg::ST_SQRT: begin
				if (cnt_q == 6'd31) begin
					state_d = hph_pkg::ST_DMX;
				end
			end
			hph_pkg::ST_DMX:  state_d = hph_pkg::ST_DIVX;
			hph_pkg::ST_DIVX: begin
				if (cnt_q == 6'd63) begin
					state_d = hph_pkg::ST_DMY;
				end
			end
			hph_pkg::ST_DMY:  state_d = hph_pkg::ST_DIVY;
			hph_pkg::ST_DIVY: begin
				if (cnt_q == 6'd63) begin
					state_d = hph_pkg::ST_DWY;
				end
			end
			hph_pkg::ST_DWY:  state_d = hph_pkg::ST_PX;
			hph_pkg::ST_PX:   state_d = hph_pkg::ST_PY;
			hph_pkg::ST_PY:   state_d = hph_pkg::ST_VX;
			hph_pkg::ST_VX:   state_d = hph_pkg::ST_VY;
			hph_pkg::ST_VY:   state_d = hph_pkg::ST_QX;
			hph_pkg::ST_QX:   state_d = hph_pkg::ST_QY;
			hph_pkg::ST_QY:   state_d = hph_pkg::ST_R1;
			hph_pkg::ST_R1:   state_d = hph_pkg::ST_R2;
			hph_pkg::ST_R2:   state_d = hph_pkg::ST_R3;
			hph_pkg::ST_R3:   state_d = hph_pkg::ST_R4;
			hph_pkg::ST_R4:   state_d = hph_pkg::ST_R5;
			hph_pkg::ST_R5: begin
				if (!out_valid_q || item_out.ready) begin
					state_d = hph_pkg::ST_IDLE;
				end
			end
			default: state_d = hph_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hph_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// config registers, controller state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= hph_pkg::POS_GAIN_RST;
			kd_q <= hph_pkg::VEL_GAIN_RST;
			lim_q <= hph_pkg::WIND_LIM_RST;
			wind_x_q <= '0;
			wind_y_q <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					hph_pkg::REG_POS_GAIN: kp_q <= cfg.data;
					hph_pkg::REG_VEL_GAIN: kd_q <= cfg.data;
					hph_pkg::REG_WIND_LIM: lim_q <= cfg.data;
					default: ;
				endcase
			end
			if (item_out.ready && state_q != hph_pkg::ST_R5) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				hph_pkg::ST_IDLE: begin
					if (accept && item_in.clear_wind) begin
						wind_x_q <= '0;
						wind_y_q <= '0;
					end
				end
				hph_pkg::ST_WMY: wind_x_q <= hph_pkg::add_s(wind_x_q, rnd_p);
				hph_pkg::ST_WAY: wind_y_q <= hph_pkg::add_s(wind_y_q, rnd_p);
				hph_pkg::ST_CCMP: cnt_q <= '0;
				hph_pkg::ST_SQRT, hph_pkg::ST_DIVX, hph_pkg::ST_DIVY: cnt_q <= cnt_q + 6'd1;
				hph_pkg::ST_DMX: cnt_q <= '0;
				hph_pkg::ST_DMY: begin
					wind_x_q <= div_res;
					cnt_q <= '0;
				end
				hph_pkg::ST_DWY: wind_y_q <= div_res;
				hph_pkg::ST_QY: last_x_q <= hph_pkg::add_s(px_q, rnd_p);
				hph_pkg::ST_R1: last_y_q <= hph_pkg::add_s(py_q, rnd_p);
				hph_pkg::ST_R5: begin
					if (!out_valid_q || item_out.ready) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath: operands, products, root and quotient
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			hph_pkg::ST_IDLE: begin
				ex_q <= item_in.est_x;
				ey_q <= item_in.est_y;
				tx_q <= item_in.target_x;
				ty_q <= item_in.target_y;
				vx_q <= item_in.vel_x;
				vy_q <= item_in.vel_y;
				yc_q <= item_in.yaw_cos;
				ys_q <= item_in.yaw_sin;
			end
			hph_pkg::ST_CSY: acc_q <= prod_q;
			hph_pkg::ST_CLIM: acc_q <= acc_q + prod_q;
			hph_pkg::ST_CCMP: begin
				sq_v_q <= acc_q[63:0];
				sq_r_q <= '0;
				sq_bit_q <= 64'd1 << 62;
			end
			// one step of the digit-by-digit square root
			hph_pkg::ST_SQRT: begin
				if (sq_v_q >= sq_t) begin
					sq_v_q <= sq_v_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			hph_pkg::ST_DMX, hph_pkg::ST_DMY: begin
				rem_q <= '0;
				neg_q <= mul_p < 0;
				quo_q <= mul_p < 0 ? 64'(-mul_p) : mul_p[63:0];
			end
			// one step of restoring division by the root
			hph_pkg::ST_DIVX, hph_pkg::ST_DIVY: begin
				if (div_t >= {1'b0, sq_r_q[31:0]}) begin
					rem_q <= 32'(div_t - {1'b0, sq_r_q[31:0]});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= div_t[31:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			hph_pkg::ST_PY: px_q <= hph_pkg::add_s(rnd_p, wind_x_q);
			hph_pkg::ST_VX: py_q <= hph_pkg::add_s(rnd_p, wind_y_q);
			hph_pkg::ST_VY: sx_q <= rnd_p;
			hph_pkg::ST_QX: sy_q <= rnd_p;
			hph_pkg::ST_R2: acc_q <= -prod_q;
			hph_pkg::ST_R3: pitch_q <= hph_pkg::rnd_sat(acc_q - prod_q);
			hph_pkg::ST_R4: acc_q <= prod_q;
			hph_pkg::ST_R5: begin
				if (!out_valid_q || item_out.ready) begin
					out_pitch_q <= pitch_q;
					out_roll_q <= hph_pkg::rnd_sat(acc_q - prod_q);
				end
			end
			default: ;
		endcase
	end

	// an accepted word always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != hph_pkg::ST_IDLE)
		else $error("accepted word did not start the sequencer");

	// a new result only appears from the last rotation step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == hph_pkg::ST_R5)
		else $error("output word loaded outside the final step");

	// divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hph_pkg::ST_DIVX || state_q == hph_pkg::ST_DIVY)
		|-> rem_q < sq_r_q[31:0])
		else $error("divider remainder out of range");

	// the root is nonzero whenever the clamp divides
	a_root_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hph_pkg::ST_DMX |-> sq_r_q != 64'd0)
		else $error("wind clamp root is zero");

endmodule
